[src/urff_pkg.sv]
// Shared types and constants for the UART receive FIFO with flow control.
// Used by the channel interfaces and the top level.
package urff_pkg;

	// action codes of an input word
	localparam logic [1:0] ACT_RX   = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_TX   = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	// handshake mode register codes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_SW   = 2'd1;
	localparam logic [1:0] MODE_HW   = 2'd2;

	// control characters
	localparam logic [7:0] CH_XON  = 8'h11;
	localparam logic [7:0] CH_XOFF = 8'h13;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;

	// error flag bit set on FIFO overflow
	localparam logic [2:0] ERR_OVERRUN = 3'b010;

	// width of the reported fill count
	localparam int FILL_W = 4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic [2:0] line_errors;
		logic       cts_blocked;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic              read_valid;
		logic              tx_valid;
		logic [7:0]        tx_byte;
		logic              tx_blocked;
		logic              rts_level;
		logic [2:0]        error_flags;
		logic              tx_paused;
		logic [FILL_W-1:0] fill_count;
		logic              last;
	} out_item_t;

endpackage

[src/urff_in_if.sv]
// Input channel of the UART receive FIFO: valid/ready plus one event word.
// Depends on urff_pkg for the payload type.
interface urff_in_if;
	logic               valid;
	logic               ready;
	urff_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/urff_out_if.sv]
// Result channel of the UART receive FIFO: valid/ready plus one result word.
// Depends on urff_pkg for the payload type.
interface urff_out_if;
	logic                valid;
	logic                ready;
	urff_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/urff_mem.sv]
// Byte store of the receive FIFO: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module urff_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/uart_rx_fifo_flow_control_unit.sv]
// Top level of the UART receive FIFO with XON/XOFF or RTS/CTS flow control.
// Depends on urff_pkg, urff_in_if, urff_out_if and urff_mem.
//
//  channel  | direction | word
//  ---------+-----------+--------------------------------------------------
//  in_ch    | sink      | action, data_byte, line_errors, cts_blocked
//  out_ch   | source    | read_data, read_valid, tx_*, rts, errors, fill, last
//  cfg      | write     | handshake_mode (cfg_we, cfg_wdata)
//
// An event's result is shown in the cycle after the event is taken;
// one event per cycle is sustained while results are taken.
// A transmitted LF yields CR then LF, so that event holds the result stage for
// both words and stalls the input until the CR is taken.
// Reset clears pointers, flags and the mode; no clearing pass of the store.
// Stalls on out_ch back up into in_ch.ready through the single result stage.
module uart_rx_fifo_flow_control_unit #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	urff_in_if.sink    in_ch,
	urff_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam logic [PW-1:0] LAST_IDX  = PW'(FIFO_DEPTH - 1);
	localparam logic [PW-1:0] FULL_MARK = PW'(FIFO_DEPTH - 1);
	localparam logic [PW-1:0] HIGH_MARK = PW'(FIFO_DEPTH - 4);

	// architectural state
	logic [1:0]    mode_q;
	logic [PW-1:0] wp_q, rp_q;
	logic          paused_q, xsent_q, rts_q;
	logic [2:0]    err_q;

	// result stage
	logic          vld_s1, two_s1;
	logic          rvalid_s1, txv_s1, blk_s1, rts_s1, paused_s1;
	logic [7:0]    txb_s1;
	logic [2:0]    err_s1;
	logic [urff_pkg::FILL_W-1:0] fill_s1;
	logic [7:0]    rdata;

	// next-state and result values
	logic          acc, out_acc;
	logic          sw, hw;
	logic [PW:0]   diff;
	logic [PW-1:0] fill, fill_n;
	logic [PW-1:0] wp_inc, rp_inc;
	logic          we, re, blocked;
	logic          paused_n, xsent_n, rts_n;
	logic [2:0]    err_n;
	logic          rvalid_n, txv_n, blk_n, two_n, res_n;
	logic [7:0]    txb_n;
	logic [PW+urff_pkg::FILL_W-1:0] fill_wide;
	urff_pkg::in_item_t it;

	assign it      = in_ch.data;
	assign acc     = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign sw      = mode_q == urff_pkg::MODE_SW;
	assign hw      = mode_q == urff_pkg::MODE_HW;

	// take a new word when the result stage is free or empties now
	assign in_ch.ready = !vld_s1 || (out_ch.ready && !two_s1);

	// current fill, modulo the depth
	assign diff   = {1'b0, wp_q} - {1'b0, rp_q};
	assign fill   = diff[PW] ? PW'(diff + (PW+1)'(FIFO_DEPTH)) : diff[PW-1:0];
	assign wp_inc = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == LAST_IDX) ? '0 : rp_q + 1'b1;

	// decide the effect of one event
	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		blocked  = (sw && paused_q) || (hw && it.cts_blocked);
		paused_n = paused_q;
		xsent_n  = xsent_q;
		rts_n    = rts_q;
		err_n    = err_q;
		fill_n   = fill;
		rvalid_n = 1'b0;
		txv_n    = 1'b0;
		txb_n    = 8'h00;
		blk_n    = 1'b0;
		two_n    = 1'b0;
		res_n    = 1'b1;
		unique case (it.action)
			urff_pkg::ACT_RX: begin
				err_n = err_q | it.line_errors;
				if (sw && it.data_byte == urff_pkg::CH_XOFF) begin
					paused_n = 1'b1;
				end else if (sw && it.data_byte == urff_pkg::CH_XON) begin
					paused_n = 1'b0;
				end else if (fill >= FULL_MARK) begin
					err_n = err_n | urff_pkg::ERR_OVERRUN;
				end else begin
					if (fill >= HIGH_MARK) begin
						if (sw && !xsent_q) begin
							txv_n   = 1'b1;
							txb_n   = urff_pkg::CH_XOFF;
							err_n   = 3'b000;
							xsent_n = 1'b1;
						end else if (hw) begin
							rts_n = 1'b1;
						end
					end
					we     = 1'b1;
					fill_n = fill + 1'b1;
				end
			end
			urff_pkg::ACT_READ: begin
				if (fill != '0) begin
					re       = 1'b1;
					rvalid_n = 1'b1;
					fill_n   = fill - 1'b1;
					if (fill_n < HIGH_MARK) begin
						if (xsent_q) begin
							txv_n   = 1'b1;
							txb_n   = urff_pkg::CH_XON;
							err_n   = 3'b000;
							xsent_n = 1'b0;
						end else if (hw) begin
							rts_n = 1'b0;
						end
					end
				end
			end
			urff_pkg::ACT_TX: begin
				if (blocked) begin
					blk_n = 1'b1;
				end else begin
					err_n = 3'b000;
					txv_n = 1'b1;
					txb_n = it.data_byte;
					two_n = it.data_byte == urff_pkg::CH_LF;
				end
			end
			urff_pkg::ACT_NONE: begin
				res_n = 1'b0;
			end
			default: begin
				res_n = 1'b0;
			end
		endcase
	end

	assign fill_wide = {{urff_pkg::FILL_W{1'b0}}, fill_n};

	// hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= urff_pkg::MODE_NONE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// advance pointers and flags on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			paused_q <= 1'b0;
			xsent_q  <= 1'b0;
			rts_q    <= 1'b0;
			err_q    <= 3'b000;
		end else if (acc) begin
			if (we) begin
				wp_q <= wp_inc;
			end
			if (re) begin
				rp_q <= rp_inc;
			end
			paused_q <= paused_n;
			xsent_q  <= xsent_n;
			rts_q    <= rts_n;
			err_q    <= err_n;
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			two_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= res_n;
			two_s1 <= res_n && two_n;
		end else if (out_acc) begin
			// CR goes first, then the LF stays for one more word
			vld_s1 <= two_s1;
			two_s1 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			rvalid_s1 <= rvalid_n;
			txv_s1    <= txv_n;
			txb_s1    <= txb_n;
			blk_s1    <= blk_n;
			rts_s1    <= rts_n;
			err_s1    <= err_n;
			paused_s1 <= paused_n;
			fill_s1   <= fill_wide[urff_pkg::FILL_W-1:0];
		end
	end

	urff_mem #(
		.DEPTH (FIFO_DEPTH),
		.AW    (PW)
	) u_mem (
		.clk   (clk),
		.we    (acc && we),
		.waddr (wp_q),
		.wdata (it.data_byte),
		.re    (acc && re),
		.raddr (rp_q),
		.rdata (rdata)
	);

	// drive the result word
	assign out_ch.valid            = vld_s1;
	assign out_ch.data.read_data   = rvalid_s1 ? rdata : 8'h00;
	assign out_ch.data.read_valid  = rvalid_s1;
	assign out_ch.data.tx_valid    = txv_s1;
	assign out_ch.data.tx_byte     = two_s1 ? urff_pkg::CH_CR : txb_s1;
	assign out_ch.data.tx_blocked  = blk_s1;
	assign out_ch.data.rts_level   = rts_s1;
	assign out_ch.data.error_flags = err_s1;
	assign out_ch.data.tx_paused   = paused_s1;
	assign out_ch.data.fill_count  = fill_s1;
	assign out_ch.data.last        = !two_s1;

	// pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LAST_IDX && rp_q <= LAST_IDX)
		else $error("FIFO pointer out of range");

	// a pending CR always sits in a valid result stage
	a_two_valid: assert property (@(posedge clk) disable iff (!arst_n)
		two_s1 |-> vld_s1)
		else $error("CR pending without a valid result");

	// after CR is taken the LF follows as the last word
	a_lf_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && two_s1) |=> (vld_s1 && !two_s1))
		else $error("LF did not follow CR");

	// a read of a non-empty FIFO advances the read pointer
	a_read_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && it.action == urff_pkg::ACT_READ && fill != '0) |=> rp_q != $past(rp_q))
		else $error("read pointer did not advance");

	// input stalls only behind a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> vld_s1)
		else $error("input stalled with empty result stage");

endmodule

[tb/uart_rx_fifo_flow_control_unit_tb.sv]
// Self-checking testbench for uart_rx_fifo_flow_control_unit: directed and random events
// in every handshake mode, with a cycle-free predictor in a small scoreboard class.
// Depends on urff_pkg, urff_in_if, urff_out_if and the top level of the block.
module uart_rx_fifo_flow_control_unit_tb;

	localparam int FIFO_DEPTH = 16;
	localparam int EVENT_GOAL = 1750;
	localparam int CALM_TAIL = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	// mode 3 is not a named mode of the block; it falls back to no flow control
	localparam logic [1:0] MODE_ALIAS_NONE = 2'd3;

	class flow_ctl_scoreboard #(int DEPTH = 16);
		logic [7:0] store [DEPTH];
		int wr_ptr = 0;
		int rd_ptr = 0;
		bit paused = 1'b0;
		bit xoff_issued = 1'b0;
		bit rts = 1'b0;
		logic [2:0] err = 3'd0;
		logic [1:0] mode = urff_pkg::MODE_NONE;
		urff_pkg::out_item_t pending_words [$];
		int mismatches = 0;
		int words_checked = 0;
		int overflow_drops = 0;
		int xoff_emitted = 0;
		int xon_emitted = 0;
		int refused_tx = 0;
		int crlf_pairs = 0;

		function int fill_level();
			return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
		endfunction

		// queue one expected word, with the status fields taken after the update
		function void push_word(logic [7:0] rdata, bit rvalid, bit txv, logic [7:0] txb,
					bit blk, bit lst);
			urff_pkg::out_item_t w;
			int fill;
			fill = fill_level();
			w.read_data = rdata;
			w.read_valid = rvalid;
			w.tx_valid = txv;
			w.tx_byte = txb;
			w.tx_blocked = blk;
			w.rts_level = rts;
			w.error_flags = err;
			w.tx_paused = paused;
			w.fill_count = fill[urff_pkg::FILL_W-1:0];
			w.last = lst;
			pending_words.push_back(w);
		endfunction

		// advance the state for one accepted event and queue its words
		function void note_event(urff_pkg::in_item_t ev);
			bit sw;
			bit hw;
			bit txv;
			logic [7:0] txb;
			logic [7:0] popped;
			int cnt;
			sw = (mode == urff_pkg::MODE_SW);
			hw = (mode == urff_pkg::MODE_HW);
			txv = 1'b0;
			txb = 8'h00;
			case (ev.action)
				urff_pkg::ACT_RX: begin
					err = err | ev.line_errors;
					if (sw && ev.data_byte == urff_pkg::CH_XOFF) begin
						paused = 1'b1;
					end else if (sw && ev.data_byte == urff_pkg::CH_XON) begin
						paused = 1'b0;
					end else begin
						cnt = fill_level();
						if (cnt >= DEPTH - 1) begin
							// drop the byte and flag the overflow
							err = err | urff_pkg::ERR_OVERRUN;
							overflow_drops++;
						end else begin
							if (cnt >= DEPTH - 4) begin
								if (sw && !xoff_issued) begin
									txv = 1'b1;
									txb = urff_pkg::CH_XOFF;
									err = 3'd0;
									xoff_issued = 1'b1;
									xoff_emitted++;
								end else if (hw) begin
									rts = 1'b1;
								end
							end
							store[wr_ptr] = ev.data_byte;
							wr_ptr = (wr_ptr + 1) % DEPTH;
						end
					end
					push_word(8'h00, 1'b0, txv, txb, 1'b0, 1'b1);
				end
				urff_pkg::ACT_READ: begin
					if (fill_level() == 0) begin
						push_word(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
					end else begin
						popped = store[rd_ptr];
						rd_ptr = (rd_ptr + 1) % DEPTH;
						// below the high-water mark: resume the partner
						if (fill_level() < DEPTH - 4) begin
							if (xoff_issued) begin
								txv = 1'b1;
								txb = urff_pkg::CH_XON;
								err = 3'd0;
								xoff_issued = 1'b0;
								xon_emitted++;
							end else if (hw) begin
								rts = 1'b0;
							end
						end
						push_word(popped, 1'b1, txv, txb, 1'b0, 1'b1);
					end
				end
				urff_pkg::ACT_TX: begin
					if ((sw && paused) || (hw && ev.cts_blocked)) begin
						refused_tx++;
						push_word(8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1);
					end else begin
						err = 3'd0;
						if (ev.data_byte == urff_pkg::CH_LF) begin
							crlf_pairs++;
							push_word(8'h00, 1'b0, 1'b1, urff_pkg::CH_CR, 1'b0, 1'b0);
						end
						push_word(8'h00, 1'b0, 1'b1, ev.data_byte, 1'b0, 1'b1);
					end
				end
				default: begin
					// ignored event: no word comes back
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
			if (got_v !== want_v)
				report_mismatch($sformatf("word %0d %s got %h want %h",
					words_checked, name, got_v, want_v));
		endtask

		// check one accepted result word against the oldest expectation
		task check_word(urff_pkg::out_item_t got);
			urff_pkg::out_item_t want;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("result word %h with nothing pending", got));
				return;
			end
			want = pending_words.pop_front();
			compare_field("read_data", got.read_data, want.read_data);
			compare_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
			compare_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
			compare_field("tx_byte", got.tx_byte, want.tx_byte);
			compare_field("tx_blocked", 8'(got.tx_blocked), 8'(want.tx_blocked));
			compare_field("rts_level", 8'(got.rts_level), 8'(want.rts_level));
			compare_field("error_flags", 8'(got.error_flags), 8'(want.error_flags));
			compare_field("tx_paused", 8'(got.tx_paused), 8'(want.tx_paused));
			compare_field("fill_count", 8'(got.fill_count), 8'(want.fill_count));
			compare_field("last", 8'(got.last), 8'(want.last));
			words_checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	urff_in_if in_ch ();
	urff_out_if out_ch ();

	flow_ctl_scoreboard #(FIFO_DEPTH) sb;
	int events_sent = 0;
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	int sink_hold = 0;
	bit tail_calm = 1'b0;

	uart_rx_fifo_flow_control_unit #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// drop ready in random bursts of random length
	always @(posedge clk) begin
		if (sink_hold == 0 && sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct)
			sink_hold = $urandom_range(1, 3);
		if (sink_hold != 0) begin
			out_ch.ready <= 1'b0;
			sink_hold--;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// check every word taken from the result channel
	always @(posedge clk) begin
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_word(out_ch.data);
	end

	// end the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
			    (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// send one event word, with an optional random gap before it
	task automatic issue(input logic [1:0] act, input logic [7:0] b, input logic [2:0] errs,
			     input logic cts);
		urff_pkg::in_item_t ev;
		ev.action = act;
		ev.data_byte = b;
		ev.line_errors = errs;
		ev.cts_blocked = cts;
		if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= ev;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		sb.note_event(ev);
		if (act != urff_pkg::ACT_NONE)
			events_sent++;
	endtask

	// hold the sender until every expected word has come back
	task automatic wait_for_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_words.size() != 0);
	endtask

	// write the mode register while the block is idle
	task automatic set_mode(input logic [1:0] m);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(15))
			0: return urff_pkg::CH_XON;
			1: return urff_pkg::CH_XOFF;
			2: return urff_pkg::CH_LF;
			3: return urff_pkg::CH_CR;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [2:0] rand_errs();
		if ($urandom_range(4) == 0)
			return 3'($urandom_range(7));
		return 3'd0;
	endfunction

	task automatic run_directed();
		// mode none: empty read, byte extremes, LF expansion, ignored event
		issue(urff_pkg::ACT_READ, 8'h00, 3'd0, 1'b0);
		issue(urff_pkg::ACT_RX, 8'h00, 3'd0, 1'b0);
		issue(urff_pkg::ACT_RX, 8'hFF, 3'd7, 1'b1);
		issue(urff_pkg::ACT_TX, 8'hFF, 3'd0, 1'b1);
		issue(urff_pkg::ACT_TX, urff_pkg::CH_LF, 3'd0, 1'b0);
		issue(urff_pkg::ACT_NONE, 8'hAA, 3'd7, 1'b1);
		issue(urff_pkg::ACT_READ, 8'h00, 3'd0, 1'b0);
		issue(urff_pkg::ACT_READ, 8'hFF, 3'd7, 1'b1);
		// software mode: swallow XOFF, refuse transmits, resume on XON
		set_mode(urff_pkg::MODE_SW);
		issue(urff_pkg::ACT_RX, urff_pkg::CH_XOFF, 3'd1, 1'b0);
		issue(urff_pkg::ACT_TX, 8'h41, 3'd0, 1'b0);
		issue(urff_pkg::ACT_TX, urff_pkg::CH_LF, 3'd0, 1'b0);
		issue(urff_pkg::ACT_RX, urff_pkg::CH_XON, 3'd4, 1'b0);
		issue(urff_pkg::ACT_TX, urff_pkg::CH_LF, 3'd0, 1'b1);
		// hardware mode: CTS blocks transmit
		set_mode(urff_pkg::MODE_HW);
		issue(urff_pkg::ACT_TX, 8'h55, 3'd0, 1'b1);
		issue(urff_pkg::ACT_TX, urff_pkg::CH_LF, 3'd0, 1'b0);
		issue(urff_pkg::ACT_RX, 8'h5A, 3'd2, 1'b0);
		issue(urff_pkg::ACT_READ, 8'h00, 3'd0, 1'b1);
		// mode 3: control bytes are plain data
		set_mode(MODE_ALIAS_NONE);
		issue(urff_pkg::ACT_RX, urff_pkg::CH_XOFF, 3'd0, 1'b0);
		issue(urff_pkg::ACT_TX, urff_pkg::CH_XON, 3'd0, 1'b1);
		issue(urff_pkg::ACT_READ, 8'h00, 3'd0, 1'b0);
	endtask

	// one random sequence: fill, drain, transmit, flow-control bytes or noise
	task automatic run_sequence();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 35) begin
			n = $urandom_range(4, 20);
			repeat (n) begin
				if ($urandom_range(9) == 0)
					issue(urff_pkg::ACT_READ, rand_byte(), rand_errs(),
						1'($urandom_range(1)));
				else
					issue(urff_pkg::ACT_RX, rand_byte(), rand_errs(),
						1'($urandom_range(1)));
			end
		end else if (kind < 63) begin
			n = $urandom_range(1, 18);
			repeat (n) issue(urff_pkg::ACT_READ, rand_byte(), rand_errs(),
				1'($urandom_range(1)));
		end else if (kind < 83) begin
			n = $urandom_range(1, 6);
			repeat (n) issue(urff_pkg::ACT_TX, rand_byte(), rand_errs(),
				1'($urandom_range(1)));
		end else if (kind < 93) begin
			issue(urff_pkg::ACT_RX, $urandom_range(1) ? urff_pkg::CH_XOFF : urff_pkg::CH_XON,
				rand_errs(), 1'b0);
			issue(urff_pkg::ACT_TX, rand_byte(), 3'd0, 1'($urandom_range(1)));
		end else if (kind < 98) begin
			issue(urff_pkg::ACT_NONE, 8'($urandom_range(255)), 3'($urandom_range(7)), 1'b1);
			issue(2'($urandom_range(3)), 8'($urandom_range(255)), 3'($urandom_range(7)),
				1'($urandom_range(1)));
		end else if (!tail_calm) begin
			wait_for_results();
		end
	endtask

	initial begin : stimulus
		int phase;
		int phase_end;
		bit calm;
		logic [1:0] m;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = urff_pkg::MODE_NONE;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		phase = 0;
		while (events_sent < EVENT_GOAL) begin
			calm = (events_sent >= EVENT_GOAL - CALM_TAIL);
			case (phase)
				0: m = urff_pkg::MODE_SW;
				1: m = urff_pkg::MODE_HW;
				2: m = urff_pkg::MODE_NONE;
				3: m = MODE_ALIAS_NONE;
				default: m = 2'($urandom_range(3));
			endcase
			set_mode(m);
			// pick idling per phase; some phases run with none at all
			case ($urandom_range(2))
				0: src_gap_pct = 0;
				1: src_gap_pct = 20;
				default: src_gap_pct = 45;
			endcase
			case ($urandom_range(2))
				0: sink_stall_pct = 0;
				1: sink_stall_pct = 20;
				default: sink_stall_pct = 45;
			endcase
			if (calm) begin
				src_gap_pct = 0;
				sink_stall_pct = 0;
			end
			tail_calm = calm;
			// keep idling phases out of the final stretch
			if (calm) begin
				phase_end = EVENT_GOAL;
			end else begin
				phase_end = events_sent + $urandom_range(120, 220);
				if (phase_end > EVENT_GOAL - CALM_TAIL)
					phase_end = EVENT_GOAL - CALM_TAIL;
			end
			while (events_sent < phase_end)
				run_sequence();
			phase++;
		end

		wait_for_results();
		repeat (8) @(posedge clk);

		$display("covered %0d events over %0d mode phases, %0d words checked",
			events_sent, phase, sb.words_checked);
		$display("overflow drops %0d, XOFF %0d, XON %0d, refused tx %0d, CR/LF pairs %0d",
			sb.overflow_drops, sb.xoff_emitted, sb.xon_emitted, sb.refused_tx,
			sb.crlf_pairs);
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[uart_rx_fifo_flow_control_unit.f]
src/urff_pkg.sv
src/urff_in_if.sv
src/urff_out_if.sv
src/urff_mem.sv
src/uart_rx_fifo_flow_control_unit.sv
tb/uart_rx_fifo_flow_control_unit_tb.sv
